// ----- sv/c2u_pkg.sv -----
// c2u_pkg: shared types and constants for the CESU-8 to UTF-8 stream converter.
// No dependencies; every other file of the block imports it.
package c2u_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // command kinds handed from the front end to the back end
    localparam logic [1:0] K_PASS1 = 2'd0;  // one byte through
    localparam logic [1:0] K_PASS2 = 2'd1;  // lone 0xED, then the byte after it
    localparam logic [1:0] K_EMIT4 = 2'd2;  // four-byte UTF-8 form of a code point

    localparam logic [BYTE_W-1:0] PAIR_LEAD = 8'hED;
    localparam logic [BYTE_W-1:0] UTF4_LEAD = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] HIGH_LO   = 8'hA0;
    localparam logic [BYTE_W-1:0] HIGH_HI   = 8'hAF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]      kind;
        logic [CP_W-1:0] data;
    } t_cmd;

endpackage

// ----- sv/c2u_if.sv -----
// c2u_in_if / c2u_out_if: valid-ready byte channels of the converter.
// Depends on c2u_pkg for widths.
interface c2u_in_if import c2u_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface c2u_out_if import c2u_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- sv/c2u_front.sv -----
// c2u_front: accepts CESU-8 bytes, tracks surrogate-pair phase, issues commands.
// Depends on c2u_pkg and c2u_in_if.
module c2u_front import c2u_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    c2u_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_B1   = 3'd1;
    localparam logic [2:0] PH_B2   = 3'd2;
    localparam logic [2:0] PH_B3   = 3'd3;
    localparam logic [2:0] PH_B4   = 3'd4;
    localparam logic [2:0] PH_B5   = 3'd5;

    logic [2:0]      r_phase, n_phase;
    logic [CP_W-1:0] r_cp, n_cp;
    logic            accept;
    logic [BYTE_W-1:0] b;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign b          = i_in.in_byte;

    always_comb begin
        n_phase   = r_phase;
        n_cp      = r_cp;
        o_push    = 1'b0;
        o_cmd     = '{kind: K_PASS1, data: {{(CP_W-BYTE_W){1'b0}}, b}};
        if (accept) begin
            case (r_phase)
                PH_B1: begin
                    if (b inside {[HIGH_LO:HIGH_HI]}) begin
                        n_cp    = {5'(b[4:0] + 5'd1), 16'd0};
                        n_phase = PH_B2;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = K_PASS2;
                        n_phase    = PH_IDLE;
                        n_cp       = '0;
                    end
                end
                PH_B2: begin
                    n_cp    = r_cp | {5'd0, b[5:0], 10'd0};
                    n_phase = PH_B3;
                end
                PH_B3: begin
                    // drop the second lead byte
                    n_phase = PH_B4;
                end
                PH_B4: begin
                    n_cp    = r_cp | {11'd0, b[3:0], 6'd0};
                    n_phase = PH_B5;
                end
                PH_B5: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_EMIT4;
                    o_cmd.data = r_cp | {15'd0, b[5:0]};
                    n_phase    = PH_IDLE;
                    n_cp       = '0;
                end
                default: begin
                    n_cp = '0;
                    if (b == PAIR_LEAD) begin
                        n_phase = PH_B1;
                    end else begin
                        o_push  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cp    <= '0;
        end else begin
            r_phase <= n_phase;
            r_cp    <= n_cp;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_B5)
        else $error("front phase out of range");

endmodule

// ----- sv/c2u_queue.sv -----
// c2u_queue: small command FIFO between front and back ends.
// Depends on c2u_pkg.
module c2u_queue import c2u_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QCW-1:0] r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= QAW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= QAW'(r_rptr + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= QCW'(r_count + 1'b1);
                2'b01:   r_count <= QCW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/c2u_back.sv -----
// c2u_back: expands queued commands into UTF-8 bytes behind an output register.
// Depends on c2u_pkg and c2u_out_if.
module c2u_back import c2u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_cmd      i_head,
    output logic      o_pop,
    c2u_out_if.source o_out
);

    logic [1:0]        r_idx, n_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_last;
    logic              load;
    logic [CP_W-1:0]   x;

    assign x    = i_head.data;
    assign load = i_head_valid && (!r_valid || o_out.ready);

    always_comb begin
        sel_byte = x[BYTE_W-1:0];
        sel_last = 1'b1;
        case (i_head.kind)
            K_PASS1: begin
                sel_byte = x[BYTE_W-1:0];
                sel_last = 1'b1;
            end
            K_PASS2: begin
                sel_byte = (r_idx == 2'd0) ? PAIR_LEAD : x[BYTE_W-1:0];
                sel_last = (r_idx != 2'd0);
            end
            K_EMIT4: begin
                case (r_idx)
                    2'd0:    sel_byte = UTF4_LEAD | {5'd0, x[20:18]};
                    2'd1:    sel_byte = CONT_MARK | {2'd0, x[17:12]};
                    2'd2:    sel_byte = CONT_MARK | {2'd0, x[11:6]};
                    default: sel_byte = CONT_MARK | {2'd0, x[5:0]};
                endcase
                sel_last = (r_idx == 2'd3);
            end
            default: begin
                sel_byte = x[BYTE_W-1:0];
                sel_last = 1'b1;
            end
        endcase
    end

    assign o_pop = load && sel_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = sel_last ? 2'd0 : 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= sel_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.run_last = r_last;

    a_idx_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_head_valid)
        else $error("expansion in progress without a queued command");

endmodule

// ----- sv/cesu8_to_utf8_stream_core.sv -----
// cesu8_to_utf8_stream_core: CESU-8 to UTF-8 byte-stream converter, top level.
// Depends on c2u_pkg, c2u_if, c2u_front, c2u_queue and c2u_back.
//
// Usage:
//   i_in  carries one CESU-8 word (in_byte) per valid/ready handshake.
//   o_out carries one UTF-8 word (out_byte) per handshake; run_last is high on
//         the last word caused by a given input word.
//   Ordinary words pass through one for one. A lone 0xED gives two words
//   (0xED, then the word after it). A six-word surrogate pair gives nothing
//   for its first five words and a four-word burst after the sixth.
// Path: an accepted input word is written into the command queue; the back
//   end then loads the output register from the queue head, and the first
//   result word shows on o_out from that register.
// Throughput: one input word and one output word per cycle. The front end
//   takes a word every cycle while the four-entry command queue has room;
//   with o_out.ready high the back end drains a word a cycle off the queue head.
// Stall: when o_out.ready is low the output register holds its word, the
//   back end stops, the queue fills, and i_in.ready drops once it is full.
//   i_in.ready never depends on o_out.ready in the same cycle.
// Reset: synchronous, active low; clears the pair phase, the queue pointers
//   and the output valid. No words are in flight afterward.
module cesu8_to_utf8_stream_core import c2u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    c2u_in_if.sink    i_in,
    c2u_out_if.source o_out
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // front end: classify each word, build pair code points
    c2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouple classification from output expansion
    c2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    // back end: expand commands into one to four output words
    c2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
